@@ design/cei_pkg.sv @@
// ----------------------------------------------------------------------------
// cei_pkg
// shared types and constants for the elliptic integral block
// ----------------------------------------------------------------------------
package cei_pkg;

  localparam int unsigned MOD_W = 33;
  localparam int unsigned RES_W = 32;

  // pi/2 in q2.62
  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
  localparam logic [31:0] ONE_Q28     = 32'h10000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KSQ,
    ST_BSQRT,
    ST_LOOP,
    ST_CSQ,
    ST_AB,
    ST_ABSQRT,
    ST_DIV,
    ST_EMUL,
    ST_DONE
  } cei_state_t;

endpackage

@@ design/cei_if.sv @@
// ----------------------------------------------------------------------------
// cei_in_if / cei_out_if
// valid/ready channels for modulus items and result items
// ----------------------------------------------------------------------------
interface cei_in_if;
  logic                      valid;
  logic                      ready;
  logic [cei_pkg::MOD_W-1:0] modulus;
  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

interface cei_out_if;
  logic                      valid;
  logic                      ready;
  logic [cei_pkg::RES_W-1:0] first_kind;
  logic [cei_pkg::RES_W-1:0] second_kind;
  logic                      k_out_of_range;
  modport source (output valid, output first_kind, output second_kind,
                  output k_out_of_range, input ready);
  modport sink   (input valid, input first_kind, input second_kind,
                  input k_out_of_range, output ready);
endinterface

@@ design/complete_elliptic_integrals_agm.sv @@
// ----------------------------------------------------------------------------
// complete_elliptic_integrals_agm
// K(k) and E(k) by the arithmetic-geometric mean on one shared unit
// ----------------------------------------------------------------------------
// One item in, one item out. A small sequencer runs all products, roots and
// quotients through one 32x32 multiplier (four partial products per
// full-width product) and one compare-subtract unit that serves both the
// restoring square root (one root bit a cycle) and the restoring divider
// (one quotient bit a cycle). An item runs through k squared and the first
// root, then per AGM step actually run (at most AGM_STEPS) a check, c
// squared, a*b and the root, then a final check, the divide and the E
// product. A modulus of zero skips the mean; a modulus of one or more
// answers on the next cycle. The input is not ready while an item is in
// flight, and the result register holds a finished item until it is taken;
// only then does the block return to idle, so the next item is accepted
// only after the last result has been taken.
// ----------------------------------------------------------------------------
module complete_elliptic_integrals_agm #(
  parameter int unsigned AGM_STEPS = 10,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  cei_in_if.sink    in_ch,
  cei_out_if.source out_ch
);
  import cei_pkg::*;

  localparam int unsigned W   = FRAC_BITS + 2;       // a, b, c width
  localparam int unsigned W2  = 2 * W;               // radicand width
  localparam int unsigned NW  = 64 + W;              // dividend width
  localparam int unsigned CW  = $clog2(NW + 1) + 1;  // bit counter
  localparam int unsigned SW  = $clog2(AGM_STEPS + 1);
  localparam int unsigned PRW = 128;                 // product width
  localparam int unsigned RW  = W + 3;               // compare-subtract width
  // k from q0.32 to FRAC_BITS fraction bits
  localparam int unsigned KUP = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int unsigned KDN = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;
  // (pi/2) * one, the dividend for K
  localparam logic [NW-1:0] DIVIDEND = NW'(PI_HALF_Q62) << FRAC_BITS;

  cei_state_t state_r, state_nxt;

  logic [W-1:0]   a_r, b_r, c_r, a_nxt, b_nxt, c_nxt;
  logic [W-1:0]   sum_r, sum_nxt;      // weighted sum, clamped at one
  logic [SW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [2:0]     pp_r, pp_nxt;        // partial product index {i, j}, 4 when done

  // shared multiplier: mx_r * my_r, summed from four partial products into prod_r
  logic [63:0]    mx_r, my_r, mx_nxt, my_nxt;
  logic [PRW-1:0] prod_r, prod_nxt;

  // square root / divide working registers
  logic [W2-1:0]  rad_r, rad_nxt;     // radicand, consumed two bits a cycle
  logic [W-1:0]   root_r, root_nxt;
  logic [NW-1:0]  quo_r, quo_nxt;     // dividend shifted into quotient
  logic [RW-1:0]  rem_r, rem_nxt;

  logic [31:0]    kq_r, kq_nxt;
  logic [31:0]    fk_r, sk_r, fk_nxt, sk_nxt;
  logic           oor_r, oor_nxt;

  // partial product select
  logic [31:0]    xs, ys;
  logic [63:0]    pp;
  logic [6:0]     pp_shamt;
  logic [PRW-1:0] pp_sh;
  logic           mul_done;

  // shared compare-subtract
  logic [RW-1:0]  cs_lhs, cs_rhs, cs_diff;
  logic           cs_ge;

  logic [W-1:0]   kf;
  logic [W-1:0]   one_w;
  logic [6:0]     csq_shamt;
  logic [PRW-1:0] csq_sh, sum_add, e_sh;
  logic [31:0]    kq_new;

  assign one_w = W'(1) << FRAC_BITS;

  // 32-bit chunk i of x times chunk j of y, placed at 32*(i+j)
  always_comb begin
    xs       = pp_r[1] ? mx_r[63:32] : mx_r[31:0];
    ys       = pp_r[0] ? my_r[63:32] : my_r[31:0];
    pp       = {32'd0, xs} * {32'd0, ys};
    pp_shamt = {pp_r[1] & pp_r[0], pp_r[1] ^ pp_r[0], 5'd0};
    pp_sh    = {64'd0, pp} << pp_shamt;
    mul_done = pp_r[2];
  end

  // divide: remainder against a; root: remainder against 4*root + 1
  always_comb begin
    if (state_r == ST_DIV) begin
      cs_lhs = {rem_r[W+1:0], quo_r[NW-1]};
      cs_rhs = RW'(a_r);
    end else begin
      cs_lhs = {rem_r[W:0], rad_r[W2-1 -: 2]};
      cs_rhs = {1'b0, root_r, 2'b01};
    end
    cs_ge   = (cs_lhs >= cs_rhs);
    cs_diff = cs_lhs - cs_rhs;
  end

  always_comb begin
    kf        = W'((64'(in_ch.modulus[31:0]) << KUP) >> KDN);
    // c0 weighted 1/2, each later c doubles its weight
    csq_shamt = 7'(FRAC_BITS + 1) - 7'(n_r);
    csq_sh    = prod_r >> csq_shamt;
    sum_add   = PRW'(sum_r) + csq_sh;
    e_sh      = prod_r >> FRAC_BITS;
    // K = quotient >> 34, saturated to 32 bits
    if (a_r == W'(0) || quo_r[NW-1:66] != '0) kq_new = 32'hFFFF_FFFF;
    else kq_new = quo_r[65:34];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.modulus[32]) state_nxt = ST_DONE;
          else if (in_ch.modulus[31:0] == 32'd0) state_nxt = ST_DIV;
          else state_nxt = ST_KSQ;
        end
      end
      ST_KSQ:    if (mul_done) state_nxt = ST_BSQRT;
      ST_BSQRT:  if (cnt_r[CW-1]) state_nxt = ST_LOOP;
      ST_LOOP:   state_nxt = (n_r < SW'(AGM_STEPS) && c_r != W'(0)) ? ST_CSQ : ST_DIV;
      ST_CSQ:    if (mul_done) state_nxt = ST_AB;
      ST_AB:     if (mul_done) state_nxt = ST_ABSQRT;
      ST_ABSQRT: if (cnt_r[CW-1]) state_nxt = ST_LOOP;
      ST_DIV:    if (cnt_r[CW-1]) state_nxt = ST_EMUL;
      ST_EMUL:   if (mul_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; sum_nxt = sum_r; n_nxt = n_r;
    cnt_nxt = cnt_r; pp_nxt = pp_r; mx_nxt = mx_r; my_nxt = my_r;
    prod_nxt = prod_r; rad_nxt = rad_r; root_nxt = root_r; quo_nxt = quo_r;
    rem_nxt = rem_r; kq_nxt = kq_r; fk_nxt = fk_r; sk_nxt = sk_r;
    oor_nxt = oor_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          a_nxt = one_w; b_nxt = one_w; c_nxt = kf; sum_nxt = '0; n_nxt = '0;
          mx_nxt = 64'(kf); my_nxt = 64'(kf); prod_nxt = '0; pp_nxt = '0;
          quo_nxt = DIVIDEND; rem_nxt = '0; cnt_nxt = CW'(NW - 1);
          // k at or above one: K undefined, E is one
          if (in_ch.modulus[32]) begin
            fk_nxt = '0; sk_nxt = ONE_Q28; oor_nxt = 1'b1;
          end
        end
      end
      ST_KSQ, ST_CSQ, ST_AB, ST_EMUL: begin
        if (!mul_done) begin
          prod_nxt = prod_r + pp_sh;
          pp_nxt   = pp_r + 3'd1;
        end else begin
          pp_nxt = '0;
          if (state_r == ST_KSQ) begin
            // b0 = sqrt(1 - k^2)
            rad_nxt  = (W2'(1) << (2 * FRAC_BITS)) - prod_r[W2-1:0];
            root_nxt = '0; rem_nxt = '0; cnt_nxt = CW'(W - 1);
          end else if (state_r == ST_CSQ) begin
            sum_nxt = (sum_add > PRW'(one_w)) ? one_w : sum_add[W-1:0];
            mx_nxt = 64'(a_r); my_nxt = 64'(b_r); prod_nxt = '0;
          end else if (state_r == ST_AB) begin
            rad_nxt = prod_r[W2-1:0]; root_nxt = '0; rem_nxt = '0;
            cnt_nxt = CW'(W - 1);
          end else begin
            sk_nxt = (e_sh[PRW-1:32] != '0) ? 32'hFFFF_FFFF : e_sh[31:0];
            fk_nxt = kq_r; oor_nxt = 1'b0;
          end
        end
      end
      ST_BSQRT, ST_ABSQRT: begin
        // restoring root, one bit a cycle
        if (!cnt_r[CW-1]) begin
          rem_nxt  = cs_ge ? cs_diff : cs_lhs;
          root_nxt = {root_r[W-2:0], cs_ge};
          rad_nxt  = rad_r << 2;
          cnt_nxt  = cnt_r - CW'(1);
        end else if (state_r == ST_BSQRT) begin
          b_nxt = root_r;
        end else begin
          a_nxt = W'(((W + 1)'(a_r) + (W + 1)'(b_r)) >> 1);
          c_nxt = (a_r > b_r) ? (a_r - b_r) >> 1 : W'(0);
          b_nxt = root_r; n_nxt = n_r + SW'(1);
        end
      end
      ST_LOOP: begin
        cnt_nxt = CW'(NW - 1); quo_nxt = DIVIDEND; rem_nxt = '0;
        mx_nxt = 64'(c_r); my_nxt = 64'(c_r); prod_nxt = '0; pp_nxt = '0;
      end
      ST_DIV: begin
        if (!cnt_r[CW-1]) begin
          rem_nxt = cs_ge ? cs_diff : cs_lhs;
          quo_nxt = {quo_r[NW-2:0], cs_ge};
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          kq_nxt = kq_new;
          mx_nxt = 64'(kq_new); my_nxt = 64'(one_w - sum_r);
          prod_nxt = '0; pp_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; sum_r <= sum_nxt; n_r <= n_nxt;
    cnt_r <= cnt_nxt; pp_r <= pp_nxt; mx_r <= mx_nxt; my_r <= my_nxt;
    prod_r <= prod_nxt; rad_r <= rad_nxt; root_r <= root_nxt; quo_r <= quo_nxt;
    rem_r <= rem_nxt; kq_r <= kq_nxt; fk_r <= fk_nxt; sk_r <= sk_nxt;
    oor_r <= oor_nxt;
  end

  // outputs
  always_comb begin
    in_ch.ready           = (state_r == ST_IDLE);
    out_ch.valid          = (state_r == ST_DONE);
    out_ch.first_kind     = fk_r;
    out_ch.second_kind    = sk_r;
    out_ch.k_out_of_range = oor_r;
  end

endmodule

@@ dv/cei_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cei_tb_if
// scoreboard package for the testbench build
// ----------------------------------------------------------------------------
// the channel interfaces come from the design folder; this file holds the
// scoreboard class shared by the top level
// ----------------------------------------------------------------------------
package cei_tb_pkg;

  typedef struct packed {
    logic [31:0] first_kind;
    logic [31:0] second_kind;
    logic        k_out_of_range;
  } integrals_t;

  class integral_scoreboard;
    integrals_t pending[$];
    int         n_bad;
    int         n_checked;

    function new();
      n_bad = 0;
      n_checked = 0;
    endfunction

    function void note_modulus(integrals_t exp_res);
      pending = {pending, exp_res};
    endfunction

    // returns a text describing the mismatch (or that nothing was pending), empty when the item matches
    function string check_result(integrals_t got);
      integrals_t want;
      string      msg;
      msg = "";
      if (pending.size() == 0) return "result with nothing pending";
      want = pending.pop_front();
      n_checked++;
      if (got.first_kind !== want.first_kind)
        msg = {msg, $sformatf(" first_kind %h/%h", got.first_kind, want.first_kind)};
      if (got.second_kind !== want.second_kind)
        msg = {msg, $sformatf(" second_kind %h/%h", got.second_kind, want.second_kind)};
      if (got.k_out_of_range !== want.k_out_of_range)
        msg = {msg, $sformatf(" k_out_of_range %b/%b", got.k_out_of_range,
                              want.k_out_of_range)};
      return msg;
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the elliptic integral block
// ----------------------------------------------------------------------------
// drives modulus items with random gaps, takes results with random stalls,
// and compares each against a bit-exact fixed-point AGM predictor
// ----------------------------------------------------------------------------
module testbench;
  import cei_pkg::*;
  import cei_tb_pkg::*;

  localparam int unsigned STEPS = 10;
  localparam int unsigned FB    = 32;
  localparam int          N_RAND = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  cei_in_if  in_ch ();
  cei_out_if out_ch ();

  complete_elliptic_integrals_agm #(.AGM_STEPS(STEPS), .FRAC_BITS(FB)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  integral_scoreboard sb;
  int  n_sent = 0;
  int  n_domain = 0;
  bit  burst_mode = 0;

  // floor square root of a 128-bit value, one bit at a time
  function automatic logic [63:0] root_floor(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // fixed-point K and E for one modulus
  function automatic integrals_t predict_integrals(logic [32:0] k);
    integrals_t   res;
    logic [63:0]  one;
    logic [63:0]  kf, a, b, c, an, bn, sum, kq, factor;
    logic [127:0] w, q;
    one = 64'd1 << FB;
    if (k[32]) begin
      res.first_kind = '0;
      res.second_kind = ONE_Q28;
      res.k_out_of_range = 1'b1;
      return res;
    end
    kf = {31'd0, k} << (FB - 32);
    a = one;
    b = root_floor((128'd1 << (2 * FB)) - {64'd0, kf} * {64'd0, kf});
    c = kf;
    sum = '0;
    for (int n = 0; n < STEPS && c != 0; n++) begin
      // c0 weighted 1/2, each later c doubles its weight
      w = ({64'd0, c} * {64'd0, c}) >> (FB + 1 - n);
      sum = sum + w[63:0];
      if (sum > one) sum = one;
      an = (a + b) >> 1;
      bn = root_floor({64'd0, a} * {64'd0, b});
      c = (a > b) ? (a - b) >> 1 : 64'd0;
      a = an;
      b = bn;
    end
    if (a == 0) kq = 64'hFFFF_FFFF;
    else begin
      q = (({64'd0, PI_HALF_Q62} * {64'd0, one}) / {64'd0, a}) >> 34;
      kq = (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
    end
    factor = one - sum;
    w = ({64'd0, kq} * {64'd0, factor}) >> FB;
    res.first_kind = kq[31:0];
    res.second_kind = (w > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    res.k_out_of_range = 1'b0;
    return res;
  endfunction

  task automatic report(string what);
    sb.n_bad++;
    $display("mismatch at %0t:%s", $realtime, what);
  endtask

  // hand one modulus to the block, waiting a random gap first
  task automatic send_modulus(logic [32:0] k);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.modulus <= 33'({$urandom, $urandom} >> 31);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.modulus <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_modulus(predict_integrals(k));
    if (k[32]) n_domain++;
    n_sent++;
  endtask

  // random modulus: mostly valid fractions, spread over the range
  function automatic logic [32:0] rand_modulus();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return {1'b1, 32'($urandom)};
    if (sel < 12) return 33'($urandom_range(0, 255));
    if (sel < 24) return {1'b0, 32'hFFFF_FFFF - 32'($urandom_range(0, 65535))};
    if (sel < 30) return 33'(1) << $urandom_range(0, 31);
    return {1'b0, 32'($urandom)};
  endfunction

  // result side: random stalls with bursts of always-ready
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // check on every accepted result
  always @(posedge clk) begin
    integrals_t got;
    string      msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.first_kind = out_ch.first_kind;
      got.second_kind = out_ch.second_kind;
      got.k_out_of_range = out_ch.k_out_of_range;
      msg = sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  initial begin
    logic [32:0] directed[$];
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.modulus = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, tiny, one half, 1/sqrt(2), near one, exactly one, bit 32 with noise, other fractions
    directed = {33'd0, 33'd1, 33'd2, 33'h0_8000_0000, 33'h0_B504_F333,
                33'h0_FFFF_FFFF, 33'h0_FFFF_FFFE, 33'h0_FFFF_0000,
                33'h1_0000_0000, 33'h1_FFFF_FFFF, 33'h1_5555_AAAA,
                33'h0_0001_0000, 33'h0_5555_5555, 33'h0_AAAA_AAAA,
                33'h0_F000_0000, 33'h0_0000_FFFF};
    foreach (directed[i]) send_modulus(directed[i]);

    for (int i = 0; i < N_RAND; i++) begin
      if (i % 200 == 0) burst_mode = ~burst_mode;
      send_modulus(rand_modulus());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d modulus items (%0d at or above one), checked %0d results",
             n_sent, n_domain, sb.n_checked);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: ~1000 items with stalls, wide margin
  initial begin
    #(10_000_000);
    $display("timeout after %0d items sent", n_sent);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
